FILE: design/ssc_pkg.sv
`timescale 1ns / 1ps

package ssc_pkg;

   // Table geometry and field widths
   localparam int TABLE_SIZE = 1024;
   localparam int ADDR_BITS  = $clog2(TABLE_SIZE);
   localparam int TOTAL_BITS = ADDR_BITS + 1;
   localparam int VALUE_BITS = 8;
   localparam int COUNT_BITS = 32;
   localparam int DIFF_BITS  = 10;

   // One write into the count table
   typedef struct packed {
      logic                  en;
      logic [ADDR_BITS-1:0]  addr;
      logic [COUNT_BITS-1:0] data;
   } tbl_wr_type;

endpackage

FILE: design/ssc_table.sv
`timescale 1ns / 1ps

module ssc_table (
   input  logic                           clock,
   input  ssc_pkg::tbl_wr_type            wr,
   input  logic [ssc_pkg::ADDR_BITS-1:0]  rd_a_addr,
   input  logic [ssc_pkg::ADDR_BITS-1:0]  rd_b_addr,
   output logic [ssc_pkg::COUNT_BITS-1:0] rd_a_data,
   output logic [ssc_pkg::COUNT_BITS-1:0] rd_b_data
);
   import ssc_pkg::*;

   logic [COUNT_BITS-1:0] mem [TABLE_SIZE];
   logic [COUNT_BITS-1:0] rd_a_ff;
   logic [COUNT_BITS-1:0] rd_b_ff;

   // Write one entry, read two entries with registered data
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

FILE: design/ssc_sat_add.sv
`timescale 1ns / 1ps

module ssc_sat_add (
   input  logic [ssc_pkg::COUNT_BITS-1:0] a,
   input  logic [ssc_pkg::COUNT_BITS-1:0] b,
   output logic [ssc_pkg::COUNT_BITS-1:0] sum,
   output logic                           sat
);
   import ssc_pkg::*;

   logic [COUNT_BITS:0] full;

   // Add with carry out; clamp to all ones on carry
   always_comb begin
      full = {1'b0, a} + {1'b0, b};
      sat  = full[COUNT_BITS];
      sum  = sat ? '1 : full[COUNT_BITS-1:0];
   end

endmodule

FILE: design/subset_sum_count_partition_diff_core.sv
`timescale 1ns / 1ps

// Partition-with-difference counter. Element values arrive one item at a time;
// each one sweeps a 1024-entry table of subset-sum counts from the top entry down
// to the element value, one read-modify-write per cycle through a single
// saturating adder. An item with last_element set then passes through a lookup
// state and a fetch state that read the answer, and then a clearing pass over all
// entries that rewrites the table for the next set; the same pass runs after
// reset. The request side is not ready during the sweep, its drain state, the
// lookup and the clearing pass. The single write port of the table paces the
// sweep and the clearing pass. The result is held in an output register, so a
// result waiting to be taken does not stop the next set's sweeps.
// The difference register may be written at any time the block is idle.
module subset_sum_count_partition_diff_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ssc_pkg::DIFF_BITS-1:0]  csr_difference,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [ssc_pkg::VALUE_BITS-1:0] req_element_value,
   input  logic                           req_last_element,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [ssc_pkg::COUNT_BITS-1:0] rsp_partition_count,
   output logic                           rsp_count_overflow,
   output logic                           rsp_sum_out_of_range
);
   import ssc_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_LOOKUP,
      ST_FETCH
   } state_type;

   state_type             state_ff, state_in;
   logic [ADDR_BITS-1:0]  clr_ff, clr_in;
   logic [ADDR_BITS-1:0]  t_ff, t_in;
   logic [ADDR_BITS-1:0]  wr_addr_ff, wr_addr_in;
   logic                  pend_ff, pend_in;
   logic [VALUE_BITS-1:0] v_ff, v_in;
   logic                  last_ff, last_in;
   logic [TOTAL_BITS-1:0] total_ff, total_in;
   logic                  ovf_ff, ovf_in;
   logic                  range_ff, range_in;
   logic [DIFF_BITS-1:0]  diff_ff, diff_in;
   logic [ADDR_BITS-1:0]  target_ff, target_in;
   logic                  hit_ff, hit_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;
   logic                  rsp_range_ff, rsp_range_in;

   logic [TOTAL_BITS:0]   grown_total;
   logic [TOTAL_BITS:0]   pair_sum;
   logic                  pair_ok;
   logic [ADDR_BITS-1:0]  rd_a_addr;
   logic [ADDR_BITS-1:0]  rd_b_addr;
   logic [COUNT_BITS-1:0] rd_a_data;
   logic [COUNT_BITS-1:0] rd_b_data;
   logic [COUNT_BITS-1:0] add_sum;
   logic                  add_sat;
   tbl_wr_type            tbl_wr;

   ssc_table u_table (
      .clock     (clock),
      .wr        (tbl_wr),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   ssc_sat_add u_add (
      .a   (rd_a_data),
      .b   (rd_b_data),
      .sum (add_sum),
      .sat (add_sat)
   );

   assign csr_ready            = 1'b1;
   assign req_ready            = (state_ff == ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_partition_count  = rsp_count_ff;
   assign rsp_count_overflow   = rsp_ovf_ff;
   assign rsp_sum_out_of_range = rsp_range_ff;

   // Grow the running total with the incoming element
   assign grown_total = {1'b0, total_ff} + (TOTAL_BITS+1)'(req_element_value);

   // Check the answer conditions and form the lookup index
   always_comb begin
      pair_sum  = {1'b0, total_ff} + (TOTAL_BITS+1)'(diff_ff);
      pair_ok   = !range_ff && (total_ff >= TOTAL_BITS'(diff_ff)) && !pair_sum[0];
      target_in = pair_sum[ADDR_BITS:1];
   end

   // Select table read addresses
   always_comb begin
      rd_a_addr = t_ff;
      rd_b_addr = t_ff - ADDR_BITS'(v_ff);
      if (state_ff == ST_LOOKUP) begin
         rd_a_addr = target_in;
      end else if (state_ff == ST_FETCH) begin
         rd_a_addr = target_ff;
      end
   end

   // Write back the sweep sum, or clear during the clearing pass
   always_comb begin
      tbl_wr.en   = pend_ff;
      tbl_wr.addr = wr_addr_ff;
      tbl_wr.data = add_sum;
      if (state_ff == ST_CLEAR) begin
         tbl_wr.en   = 1'b1;
         tbl_wr.addr = clr_ff;
         tbl_wr.data = COUNT_BITS'(clr_ff == '0);
      end
   end

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      t_in         = t_ff;
      wr_addr_in   = t_ff;
      pend_in      = 1'b0;
      v_in         = v_ff;
      last_in      = last_ff;
      total_in     = total_ff;
      ovf_in       = ovf_ff || (pend_ff && add_sat);
      range_in     = range_ff;
      diff_in      = csr_valid ? csr_difference : diff_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_count_in = rsp_count_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_range_in = rsp_range_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ADDR_BITS'(TABLE_SIZE - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               v_in    = req_element_value;
               last_in = req_last_element;
               t_in    = ADDR_BITS'(TABLE_SIZE - 1);
               if (grown_total > (TOTAL_BITS+1)'(TABLE_SIZE - 1)) begin
                  total_in = TOTAL_BITS'(TABLE_SIZE);
                  range_in = 1'b1;
               end else begin
                  total_in = grown_total[TOTAL_BITS-1:0];
               end
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            // Issue reads at t and t - v; the write lands next cycle
            pend_in = 1'b1;
            if (t_ff == ADDR_BITS'(v_ff)) begin
               state_in = ST_DRAIN;
            end else begin
               t_in = t_ff - 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = last_ff ? ST_LOOKUP : ST_IDLE;
         end
         ST_LOOKUP: begin
            hit_in   = pair_ok;
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = hit_ff ? rd_a_data : '0;
               rsp_ovf_in   = ovf_ff;
               rsp_range_in = range_ff;
               total_in     = '0;
               ovf_in       = 1'b0;
               range_in     = 1'b0;
               clr_in       = '0;
               state_in     = ST_CLEAR;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         range_ff     <= 1'b0;
         diff_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         total_ff     <= total_in;
         ovf_ff       <= ovf_in;
         range_ff     <= range_in;
         diff_ff      <= diff_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      t_ff         <= t_in;
      wr_addr_ff   <= wr_addr_in;
      v_ff         <= v_in;
      last_ff      <= last_in;
      target_ff    <= target_in;
      hit_ff       <= hit_in;
      rsp_count_ff <= rsp_count_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_range_ff <= rsp_range_in;
   end

   // A pending sweep write never collides with the clearing pass
   assert property (@(posedge clock) disable iff (reset)
      !(state_ff == ST_CLEAR && pend_ff))
      else $error("sweep write pending during clearing pass");

   // No sweep write is left over when a new item can be taken
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !pend_ff)
      else $error("ready with a sweep write outstanding");

   // A new result only follows the lookup
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FETCH))
      else $error("result appeared outside the lookup");

   // An out-of-range total is pinned at the table size
   assert property (@(posedge clock) disable iff (reset)
      range_ff |-> (total_ff == TOTAL_BITS'(TABLE_SIZE)))
      else $error("range flag set with total below table size");

   // The sweep index never drops below the element value
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (t_ff >= ADDR_BITS'(v_ff)))
      else $error("sweep index below element value");

endmodule
